// File: rtl/core/tvi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_pkg: shared types and constants of the temperature to voltage core
// Table geometry, field widths, divider geometry, operation codes and the table entry type.
// ----------------------------------------------------------------------------
package tvi_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 16;

  // divider geometry: magnitude of the product fits in 32 bits
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  // operation codes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // one table point
  typedef struct packed {
    logic [DATA_W-1:0] temp;
    logic [DATA_W-1:0] volt;
  } tvi_entry_t;

endpackage

// File: rtl/core/tvi_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_table: point table storage
// One write port, one registered read port; per-entry valid bits make
// never-written entries read back as an all-zero pair.
// ----------------------------------------------------------------------------
module tvi_table import tvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [TBL_AW-1:0] wr_addr,
  input  tvi_entry_t        wr_ent,
  input  logic [TBL_AW-1:0] rd_addr,
  output tvi_entry_t        rd_ent
);

  tvi_entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  tvi_entry_t             rd_ent_r;

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  // registered read, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (vld_r[rd_addr]) begin
      rd_ent_r <= mem[rd_addr];
    end else begin
      rd_ent_r <= '0;
    end
  end

  assign rd_ent = rd_ent_r;

endmodule

// File: rtl/core/tvi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvi_div import tvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic              run_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dsr_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;

  // one restoring step
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    take  = (trial >= {1'b0, dsr_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/temperature_to_voltage_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_to_voltage_interpolator_core: table based temperature to voltage
// Stores temperature/voltage points and converts a temperature by
// piecewise linear interpolation with clamping at both table ends.
// ----------------------------------------------------------------------------
// A write item (in_operation low) stores one point in the cycle start is
// taken and gives no result. A convert item scans the table through its one
// read port, reading in S_RD and checking in S_CHK, until table_length
// entries (capped at the table depth) or the first all-zero pair; a clamped
// or invalid result is then given from S_EVAL, an interpolated one after the
// multiply in S_MUL, the divider launch in S_DIVGO and the 32-step divider
// in S_DIV. busy stays high for the whole convert item and drops in the
// cycle the result appears. Each result shows on out_voltage/out_status for
// exactly one cycle with out_valid; the receiver cannot stall it, so it must
// take it then. The user must write table_length through cfg_valid/cfg_ready
// only while the core is idle; the core does not enforce this, and cfg_ready
// is always high. No clearing pass is needed after reset.
module temperature_to_voltage_interpolator_core import tvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [DATA_W-1:0] in_entry_temperature,
  input  logic [DATA_W-1:0] in_entry_voltage,
  input  logic [DATA_W-1:0] in_temperature,
  // result channel
  output logic              out_valid,
  output logic [DATA_W-1:0] out_voltage,
  output logic              out_status,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  localparam int WEXT_W = IDX_W + TBL_AW;
  localparam int LEXT_W = LEN_W + TBL_CW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_EVAL,
    S_MUL,
    S_DIVGO,
    S_DIV
  } state_t;

  state_t                   state_r;
  logic [LEN_W-1:0]         table_length_r;
  logic [TBL_CW-1:0]        idx_r;
  logic [TBL_CW-1:0]        limit_r;
  logic [TBL_CW-1:0]        cnt_r;
  logic [TBL_CW-1:0]        kidx_r;
  logic                     found_r;
  logic signed [DATA_W-1:0] t_r;
  logic signed [DATA_W-1:0] t0_r;
  logic [DATA_W-1:0]        v0_r;
  logic signed [DATA_W-1:0] last_t_r;
  logic [DATA_W-1:0]        last_v_r;
  logic signed [DATA_W-1:0] prev_t_r;
  logic [DATA_W-1:0]        prev_v_r;
  logic signed [DATA_W-1:0] kp_t_r;
  logic [DATA_W-1:0]        kp_v_r;
  logic signed [DATA_W-1:0] kn_t_r;
  logic [DATA_W-1:0]        kn_v_r;
  logic signed [DATA_W:0]   dt_r;
  logic signed [DATA_W:0]   dv_r;
  logic [DATA_W-1:0]        dn_r;
  logic [DATA_W-1:0]        vp_r;
  logic signed [2*DATA_W+1:0] prod_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_voltage_r;
  logic                     out_status_r;

  logic                     accept;
  logic                     wr_en;
  logic [WEXT_W-1:0]        wr_idx_ext;
  logic [LEXT_W-1:0]        len_ext;
  logic [TBL_CW-1:0]        limit_nxt;
  tvi_entry_t               wr_ent;
  tvi_entry_t               rd_ent;
  logic signed [DATA_W-1:0] rd_t;
  logic                     rd_zero;
  logic [TBL_CW-1:0]        idx_inc;
  logic                     use_k;
  logic signed [DATA_W-1:0] sel_tp;
  logic signed [DATA_W-1:0] sel_tn;
  logic [DATA_W-1:0]        sel_vp;
  logic [DATA_W-1:0]        sel_vn;
  logic signed [DATA_W:0]   span;
  logic [2*DATA_W+1:0]      prod_abs;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [DATA_W-1:0]        q_lo;

  // command transfer and table write decode
  assign accept     = start && !busy;
  assign wr_en      = accept && (in_operation == OP_WRITE) &&
                      (32'(in_entry_index) < 32'(TABLE_DEPTH));
  assign wr_idx_ext = WEXT_W'(in_entry_index);
  assign wr_ent     = {in_entry_temperature, in_entry_voltage};

  // search limit: table_length capped at the table depth
  always_comb begin
    len_ext = LEXT_W'(table_length_r);
    if (len_ext > LEXT_W'(TABLE_DEPTH)) begin
      limit_nxt = TBL_CW'(TABLE_DEPTH);
    end else begin
      limit_nxt = len_ext[TBL_CW-1:0];
    end
  end

  tvi_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[TBL_AW-1:0]),
    .wr_ent  (wr_ent),
    .rd_addr (idx_r[TBL_AW-1:0]),
    .rd_ent  (rd_ent)
  );

  // scan decode
  assign rd_t    = $signed(rd_ent.temp);
  assign rd_zero = (rd_ent.temp == '0) && (rd_ent.volt == '0);
  assign idx_inc = idx_r + TBL_CW'(1);

  // interpolation pair: first entry not below t, else the last two entries
  always_comb begin
    use_k = found_r && ((kidx_r + TBL_CW'(1)) < cnt_r);
    if (use_k) begin
      sel_tp = kp_t_r;
      sel_vp = kp_v_r;
      sel_tn = kn_t_r;
      sel_vn = kn_v_r;
    end else begin
      sel_tp = prev_t_r;
      sel_vp = prev_v_r;
      sel_tn = last_t_r;
      sel_vn = last_v_r;
    end
    span = {sel_tn[DATA_W-1], sel_tn} - {sel_tp[DATA_W-1], sel_tp};
  end

  // product magnitude for the divider
  assign prod_abs  = prod_r[2*DATA_W+1] ? 34'(-prod_r) : 34'(prod_r);
  assign div_start = (state_r == S_DIVGO);

  tvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[DIV_W-1:0]),
    .divisor  (dn_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_lo = div_quo[DATA_W-1:0];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_length_r <= cfg_data;
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      limit_r     <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_operation == OP_CONVERT)) begin
            t_r     <= $signed(in_temperature);
            idx_r   <= '0;
            cnt_r   <= '0;
            found_r <= 1'b0;
            limit_r <= limit_nxt;
            state_r <= (limit_nxt == '0) ? S_EVAL : S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (rd_zero) begin
            cnt_r   <= idx_r;
            state_r <= S_EVAL;
          end else begin
            if (idx_r == '0) begin
              t0_r <= rd_t;
              v0_r <= rd_ent.volt;
            end
            prev_t_r <= last_t_r;
            prev_v_r <= last_v_r;
            last_t_r <= rd_t;
            last_v_r <= rd_ent.volt;
            if ((idx_r != '0) && !found_r && (rd_t >= t_r)) begin
              found_r <= 1'b1;
              kidx_r  <= idx_r;
              kp_t_r  <= last_t_r;
              kp_v_r  <= last_v_r;
              kn_t_r  <= rd_t;
              kn_v_r  <= rd_ent.volt;
            end
            idx_r <= idx_inc;
            if (idx_inc == limit_r) begin
              cnt_r   <= idx_inc;
              state_r <= S_EVAL;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_EVAL: begin
          if (cnt_r == '0) begin
            out_voltage_r <= '0;
            out_status_r  <= 1'b1;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end else if (t_r <= t0_r) begin
            out_voltage_r <= v0_r;
            out_status_r  <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end else if (t_r >= last_t_r) begin
            out_voltage_r <= last_v_r;
            out_status_r  <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end else begin
            dt_r    <= {t_r[DATA_W-1], t_r} - {sel_tp[DATA_W-1], sel_tp};
            dv_r    <= $signed({1'b0, sel_vp}) - $signed({1'b0, sel_vn});
            dn_r    <= span[DATA_W-1:0];
            vp_r    <= sel_vp;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= dt_r * dv_r;
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            // dt is positive, so the quotient takes the sign of dv
            out_voltage_r <= dv_r[DATA_W] ? (vp_r + q_lo) : (vp_r - q_lo);
            out_status_r  <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // port drive
  assign busy        = (state_r != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_voltage = out_voltage_r;
  assign out_status  = out_status_r;

  // a result only ends a convert that was in progress
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a convert in progress");

  // an invalid status always carries a zero voltage
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_voltage == '0))
    else $error("invalid status with nonzero voltage");

  // the divider only finishes while the sequencer waits on it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the wait state");

  // the scan never reads past the search limit
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (idx_r < limit_r))
    else $error("table scan beyond limit");

  // a table write never starts a convert
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !busy)
    else $error("table write left the core busy");

endmodule
